### hw/rtl/crc16_packet_deframer_assert.svh
// Assertion macros used by the deframer top level.
`ifndef CRC16_PACKET_DEFRAMER_ASSERT_SVH
`define CRC16_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CRC16PD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crc16pd assertion failed");

// Next-cycle implication.
`define CRC16PD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crc16pd assertion failed");

`endif

### hw/rtl/crc16pd_pkg.sv
// Types, constants and the CRC step shared by the deframer modules.
`default_nettype none
package crc16pd_pkg;

	localparam logic [7:0]  START_SHORT = 8'h02;
	localparam logic [7:0]  START_LONG  = 8'h03;
	localparam logic [7:0]  END_BYTE    = 8'h03;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic CFG_MAX_PAYLOAD   = 1'b0;
	localparam logic CFG_TIMEOUT_TICKS = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_CRC      = 3'd1;
	localparam logic [2:0] ST_END_BYTE = 3'd2;
	localparam logic [2:0] ST_LENGTH   = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;

	typedef enum logic [6:0] {
		PH_HUNT    = 7'b0000001,
		PH_LEN_HI  = 7'b0000010,
		PH_LEN_LO  = 7'b0000100,
		PH_PAYLOAD = 7'b0001000,
		PH_CRC_HI  = 7'b0010000,
		PH_CRC_LO  = 7'b0100000,
		PH_END     = 7'b1000000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic        long_frame;
		logic [15:0] declared_length;
		logic [15:0] bytes_seen;
		logic [15:0] running_crc;
		logic [15:0] received_crc;
		logic [15:0] idle_count;
	} frame_state_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  data_byte;
		logic        frame_end;
		logic [2:0]  frame_status;
		logic [15:0] payload_length;
	} result_t;

	localparam frame_state_t STATE_RESET = '{
		phase:           PH_HUNT,
		long_frame:      1'b0,
		declared_length: 16'h0000,
		bytes_seen:      16'h0000,
		running_crc:     16'h0000,
		received_crc:    16'h0000,
		idle_count:      16'h0000
	};

	// CRC16, poly 0x1021, MSB first, one byte per call
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/crc16pd_state_mem.sv
// Frame context memory: synchronous read, write-back, forwarding of a same-edge write.
`default_nettype none
module crc16pd_state_mem
	import crc16pd_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          rd_en,
	input  wire          we,
	input  frame_state_t wdata,
	output frame_state_t rdata
);

	frame_state_t mem [1];
	frame_state_t rd_q;
	frame_state_t wfwd_q;
	logic         ent_valid_q;
	logic         rd_inv_q;
	logic         fwd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[0] <= wdata;
			wfwd_q <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
			rd_inv_q    <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			if (we) begin
				ent_valid_q <= 1'b1;
			end
			if (rd_en) begin
				rd_inv_q <= !ent_valid_q;
				fwd_q    <= we;	// read raced a write-back: use the written value
			end
		end
	end

	assign rdata = fwd_q ? wfwd_q : (rd_inv_q ? STATE_RESET : rd_q);

endmodule
`default_nettype wire

### hw/rtl/crc16pd_frame_logic.sv
// Per-item frame update: next context and the optional result.
`default_nettype none
module crc16pd_frame_logic
	import crc16pd_pkg::*;
(
	input  frame_state_t cur,
	input  wire          req_type,
	input  wire  [7:0]   rx_byte,
	input  wire  [15:0]  max_payload,
	input  wire  [15:0]  timeout_ticks,
	output frame_state_t nxt,
	output result_t      res
);

	logic [15:0] crc_new;
	logic [15:0] cnt_inc;
	logic [15:0] len_full;
	logic [15:0] idle_inc;

	assign crc_new  = crc16_step(cur.running_crc, rx_byte);
	assign cnt_inc  = cur.bytes_seen + 16'd1;
	assign len_full = cur.declared_length | {8'h00, rx_byte};
	assign idle_inc = (cur.idle_count != IDLE_MAX) ? (cur.idle_count + 16'd1) : cur.idle_count;

	always_comb begin
		nxt = cur;
		res = '0;
		if (req_type == REQ_TICK) begin
			if (cur.phase != PH_HUNT) begin
				nxt.idle_count = idle_inc;
				if (idle_inc >= timeout_ticks) begin
					res.valid          = 1'b1;
					res.frame_end      = 1'b1;
					res.frame_status   = ST_TIMEOUT;
					res.payload_length = cur.declared_length;
					nxt.phase          = PH_HUNT;
					nxt.idle_count     = 16'h0000;
				end
			end
		end else begin
			nxt.idle_count = 16'h0000;
			case (cur.phase)
				PH_HUNT: begin
					if (rx_byte == START_SHORT || rx_byte == START_LONG) begin
						nxt.long_frame      = (rx_byte == START_LONG);
						nxt.declared_length = 16'h0000;
						nxt.bytes_seen      = 16'h0000;
						nxt.running_crc     = 16'h0000;
						nxt.received_crc    = 16'h0000;
						nxt.phase           = (rx_byte == START_LONG) ? PH_LEN_HI : PH_LEN_LO;
					end
				end
				PH_LEN_HI: begin
					nxt.declared_length = {rx_byte, 8'h00};
					nxt.phase           = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					nxt.declared_length = len_full;
					if (len_full == 16'h0000 || len_full > max_payload) begin
						res.valid          = 1'b1;
						res.frame_end      = 1'b1;
						res.frame_status   = ST_LENGTH;
						res.payload_length = len_full;
						nxt.phase          = PH_HUNT;
					end else begin
						nxt.phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					nxt.running_crc = crc_new;
					nxt.bytes_seen  = cnt_inc;
					if (cnt_inc >= cur.declared_length) begin
						nxt.phase = PH_CRC_HI;
					end
					res.valid     = 1'b1;
					res.data_byte = rx_byte;
				end
				PH_CRC_HI: begin
					nxt.received_crc = {rx_byte, 8'h00};
					nxt.phase        = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					nxt.received_crc = cur.received_crc | {8'h00, rx_byte};
					nxt.phase        = PH_END;
				end
				PH_END: begin
					res.valid          = 1'b1;
					res.frame_end      = 1'b1;
					res.payload_length = cur.declared_length;
					nxt.phase          = PH_HUNT;
					// end byte is checked before the CRC
					if (rx_byte != END_BYTE) begin
						res.frame_status = ST_END_BYTE;
					end else if (cur.received_crc != cur.running_crc) begin
						res.frame_status = ST_CRC;
					end else begin
						res.frame_status = ST_OK;
					end
				end
				default: begin
					nxt.phase = PH_HUNT;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/crc16_packet_deframer.sv
// Top level of the CRC16 serial frame deframer.
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ----------------------------------------
//  in       sink       in_valid / in_ready   req_type, rx_byte
//  out      source     out_valid / out_ready data_byte, frame_end, frame_status,
//                                            payload_length
//  cfg      sink       cfg_we (no wait)      cfg_index, cfg_data
//
// One item per cycle sustained unless the output stalls. An accepted
// item issues a read of the frame context memory; in the next cycle
// the context and the item pass through the update logic, and the new
// context is written back when the stage advances. A read issued at the
// same edge as a write-back takes the written value by forwarding.
// Reset clears control flops only; the context entry reads as its reset
// value until first written. The output register stalls the update stage
// only when the item has a result and the held result is not taken.
`default_nettype none
`include "crc16_packet_deframer_assert.svh"
module crc16_packet_deframer
	import crc16pd_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,

	input  wire         in_valid,
	output logic        in_ready,
	input  wire         req_type,
	input  wire  [7:0]  rx_byte,

	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  data_byte,
	output logic        frame_end,
	output logic [2:0]  frame_status,
	output logic [15:0] payload_length,

	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);

	// configuration
	logic [15:0] max_payload_q;
	logic [15:0] timeout_ticks_q;

	// update stage
	logic        valid_s1;
	logic        req_type_s1;
	logic [7:0]  rx_byte_s1;

	// result register
	logic        out_valid_q;
	result_t     res_q;

	frame_state_t cur_state;
	frame_state_t nxt_state;
	result_t      res;
	logic         accept;
	logic         slot_free;
	logic         adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q   <= 16'd128;
			timeout_ticks_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_PAYLOAD:   max_payload_q   <= cfg_data;
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage moves on when it has no result or the output slot is free
	assign slot_free = !out_valid_q || out_ready;
	assign adv_s1    = valid_s1 && (!res.valid || slot_free);
	assign in_ready  = !valid_s1 || adv_s1;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_type;
			rx_byte_s1  <= rx_byte;
		end
	end

	crc16pd_state_mem u_state_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.we     (adv_s1),
		.wdata  (nxt_state),
		.rdata  (cur_state)
	);

	crc16pd_frame_logic u_frame_logic (
		.cur           (cur_state),
		.req_type      (req_type_s1),
		.rx_byte       (rx_byte_s1),
		.max_payload   (max_payload_q),
		.timeout_ticks (timeout_ticks_q),
		.nxt           (nxt_state),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.valid) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_byte      = res_q.data_byte;
	assign frame_end      = res_q.frame_end;
	assign frame_status   = res_q.frame_status;
	assign payload_length = res_q.payload_length;

	// payload-byte results carry no status or length
	`CRC16PD_ASSERT_IMP(a_byte_fields, clk, arst_n, out_valid && !frame_end, frame_status == ST_OK && payload_length == 16'h0000)
	// status code stays within the defined set
	`CRC16PD_ASSERT_IMP(a_status_range, clk, arst_n, out_valid, frame_status <= ST_TIMEOUT)
	// an empty update stage never blocks the input
	`CRC16PD_ASSERT_IMP(a_empty_ready, clk, arst_n, !valid_s1, in_ready)
	// update stage only holds when a result is blocked at the output
	`CRC16PD_ASSERT_IMP(a_stall_cause, clk, arst_n, valid_s1 && !adv_s1, out_valid && !out_ready && res.valid)
	// a held result that is not taken is still there next cycle
	`CRC16PD_ASSERT_NXT(a_result_kept, clk, arst_n, out_valid && !out_ready, out_valid)

endmodule
`default_nettype wire

### dv/tb_crc16_packet_deframer.sv
// Self-checking testbench for the CRC16 serial frame deframer.
`timescale 1ns / 1ps

module tb_crc16_packet_deframer;
	import crc16pd_pkg::*;

	// Run shape
	localparam int CYCLE_LIMIT     = 200000; // far above the slowest legal run
	localparam int DRAIN_CYCLES    = 6;      // margin for items still in the pipeline
	localparam int HOLD_CYCLES     = 300;    // long receiver hold-off
	localparam int ITEMS_PER_PHASE = 125;    // six random phases, ~750 frame items

	// Serial side item: one received byte or one time tick
	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} serial_item_t;

	// One deframer output: a payload byte or the end-of-frame status
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        frame_end;
		logic [2:0]  frame_status;
		logic [15:0] payload_length;
	} deframed_t;

	// How a generated frame is shaped
	typedef enum {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_END,
		FR_BAD_LEN,
		FR_TIMEOUT
	} frame_kind_t;

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic        req_type       = REQ_BYTE;
	logic [7:0]  rx_byte        = 8'h00;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [7:0]  data_byte;
	logic        frame_end;
	logic [2:0]  frame_status;
	logic [15:0] payload_length;
	logic        cfg_we         = 1'b0;
	logic        cfg_index      = CFG_MAX_PAYLOAD;
	logic [15:0] cfg_data       = 16'h0000;

	// Traffic shaping knobs, changed by the stimulus with nonblocking writes
	logic bursts_on = 1'b1;
	logic recv_hold = 1'b0;

	serial_item_t serial_queue[$];   // items waiting for the driver
	deframed_t    deframed_queue[$]; // outputs predicted, not yet seen
	int           send_gap    = 0;
	int           recv_gap    = 0;
	int           mismatches  = 0;
	int           frame_items = 0;
	int           cycles      = 0;

	// Predictor copy of the registers and of the frame context
	logic [15:0] lim_payload = 16'd128;
	logic [15:0] lim_timeout = 16'd100;
	phase_t      fr_phase    = PH_HUNT;
	logic        fr_long     = 1'b0;
	logic [15:0] fr_len      = '0;
	logic [15:0] fr_count    = '0;
	logic [15:0] fr_crc      = '0;
	logic [15:0] fr_crc_rx   = '0;
	logic [15:0] fr_idle     = '0;

	crc16_packet_deframer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.data_byte      (data_byte),
		.frame_end      (frame_end),
		.frame_status   (frame_status),
		.payload_length (payload_length),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// CRC16 0x1021, MSB first, zero init: one input bit per loop pass
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return crc;
	endfunction

	// End-of-frame output; the context falls back to hunting
	function automatic deframed_t frame_close(input logic [2:0] status);
		deframed_t r;
		r.data_byte      = 8'h00;
		r.frame_end      = 1'b1;
		r.frame_status   = status;
		r.payload_length = fr_len;
		fr_phase = PH_HUNT;
		fr_idle  = '0;
		return r;
	endfunction

	// Advance the frame context by one item; returns 1 when it gives an output
	function automatic bit deframe_step(input logic kind, input logic [7:0] b,
			output deframed_t res);
		res = '0;
		if (kind == REQ_TICK) begin
			// ticks only count inside an open frame
			if (fr_phase == PH_HUNT)
				return 1'b0;
			if (fr_idle != IDLE_MAX)
				fr_idle = fr_idle + 16'd1;
			if (fr_idle >= lim_timeout) begin
				res = frame_close(ST_TIMEOUT);
				return 1'b1;
			end
			return 1'b0;
		end
		fr_idle = '0;
		case (fr_phase)
			PH_HUNT: begin
				if (b == START_SHORT || b == START_LONG) begin
					fr_long   = (b == START_LONG);
					fr_len    = '0;
					fr_count  = '0;
					fr_crc    = '0;
					fr_crc_rx = '0;
					if (fr_long)
						fr_phase = PH_LEN_HI;
					else
						fr_phase = PH_LEN_LO;
				end
				return 1'b0;
			end
			PH_LEN_HI: begin
				fr_len   = {b, 8'h00};
				fr_phase = PH_LEN_LO;
				return 1'b0;
			end
			PH_LEN_LO: begin
				fr_len = fr_len | {8'h00, b};
				if (fr_len == 16'h0000 || fr_len > lim_payload) begin
					res = frame_close(ST_LENGTH);
					return 1'b1;
				end
				fr_phase = PH_PAYLOAD;
				return 1'b0;
			end
			PH_PAYLOAD: begin
				fr_crc   = crc_update(fr_crc, b);
				fr_count = fr_count + 16'd1;
				if (fr_count >= fr_len)
					fr_phase = PH_CRC_HI;
				res.data_byte = b;
				return 1'b1;
			end
			PH_CRC_HI: begin
				fr_crc_rx = {b, 8'h00};
				fr_phase  = PH_CRC_LO;
				return 1'b0;
			end
			PH_CRC_LO: begin
				fr_crc_rx = fr_crc_rx | {8'h00, b};
				fr_phase  = PH_END;
				return 1'b0;
			end
			PH_END: begin
				// a bad end byte outranks a CRC mismatch
				if (b != END_BYTE)
					res = frame_close(ST_END_BYTE);
				else if (fr_crc_rx != fr_crc)
					res = frame_close(ST_CRC);
				else
					res = frame_close(ST_OK);
				return 1'b1;
			end
			default: begin
				fr_phase = PH_HUNT;
				return 1'b0;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: serial items from the queue, random idle bursts
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_serial
		serial_item_t nxt;
		deframed_t    res;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// predict at the accepting edge, from the values still on the pins
			if (in_valid && in_ready) begin
				if (deframe_step(req_type, rx_byte, res))
					deframed_queue.push_back(res);
			end
			// valid only drops after an accept; the payload holds while waiting
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap = send_gap - 1;
					in_valid <= 1'b0;
				end else if (bursts_on && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else if (serial_queue.size() != 0) begin
					nxt = serial_queue.pop_front();
					req_type <= nxt.req_type;
					rx_byte  <= nxt.rx_byte;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each accepted output with the oldest prediction
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_output
		deframed_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (deframed_queue.size() == 0) begin
					$error("output with nothing predicted: data_byte 0x%0h frame_end %0b",
						data_byte, frame_end);
					mismatches++;
				end else begin
					want = deframed_queue.pop_front();
					check_field("data_byte", want.data_byte, data_byte);
					check_field("frame_end", want.frame_end, frame_end);
					check_field("frame_status", want.frame_status, frame_status);
					check_field("payload_length", want.payload_length, payload_length);
				end
			end
			// ready pattern: long hold-off, random stall bursts, or ready
			if (recv_hold) begin
				out_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap = recv_gap - 1;
				out_ready <= 1'b0;
			end else if (bursts_on && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 14);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b);
		serial_queue.push_back('{req_type: REQ_BYTE, rx_byte: b});
	endtask

	// rx_byte is don't-care on a tick, so it gets noise
	task automatic push_tick();
		serial_queue.push_back('{req_type: REQ_TICK, rx_byte: 8'($urandom)});
	endtask

	// Register write; the block is drained before every call
	task automatic cfg_write(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_PAYLOAD)
			lim_payload = val;
		else
			lim_timeout = val;
	endtask

	// Sender pauses until every predicted output is in, then lets items
	// that give no output clear the pipeline
	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (serial_queue.size() != 0 || in_valid || deframed_queue.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Build one frame of the given shape and queue it, with idle ticks
	// sprinkled in below the timeout
	task automatic build_frame(input frame_kind_t kind, input logic is_long,
			input logic [15:0] len);
		logic [7:0]  seq[$];
		logic [15:0] crc;
		logic [7:0]  endb;
		int          cut;
		int          n;
		seq.push_back(is_long ? START_LONG : START_SHORT);
		if (is_long)
			seq.push_back(len[15:8]);
		seq.push_back(len[7:0]);
		if (kind != FR_BAD_LEN) begin
			crc = '0;
			for (int i = 0; i < int'(len); i++) begin
				seq.push_back(8'($urandom));
				crc = crc_update(crc, seq[seq.size() - 1]);
			end
			// a bad end byte sometimes comes with a bad CRC too
			if (kind == FR_BAD_CRC || (kind == FR_BAD_END && $urandom_range(0, 1) == 1))
				crc = crc ^ 16'($urandom_range(1, 65535));
			seq.push_back(crc[15:8]);
			seq.push_back(crc[7:0]);
			endb = END_BYTE;
			if (kind == FR_BAD_END) begin
				endb = 8'($urandom);
				if (endb == END_BYTE)
					endb = ~endb;
			end
			seq.push_back(endb);
		end
		// timeout frames stop anywhere after the start byte
		if (kind == FR_TIMEOUT) begin
			cut = $urandom_range(1, seq.size() - 1);
			while (seq.size() > cut)
				void'(seq.pop_back());
		end
		for (int i = 0; i < seq.size(); i++) begin
			if (i > 0 && lim_timeout > 16'd1 && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, (lim_timeout > 16'd5) ? 4 : int'(lim_timeout) - 1);
				repeat (n) push_tick();
				frame_items += n;
			end
			push_byte(seq[i]);
		end
		frame_items += seq.size();
		if (kind == FR_TIMEOUT) begin
			repeat (int'(lim_timeout)) push_tick();
			frame_items += int'(lim_timeout);
		end
	endtask

	// Mostly well-formed frames with random content; some noise and breakage
	task automatic random_frame();
		int unsigned r;
		int unsigned cap;
		logic        is_long;
		logic [15:0] len;
		logic [7:0]  b;
		frame_kind_t kind;
		r       = $urandom_range(0, 99);
		is_long = 1'($urandom_range(0, 1));
		cap     = (lim_payload < 16'd24) ? int'(lim_payload) : 24;
		if (r < 6) begin
			// line noise while hunting; start bytes kept out
			repeat ($urandom_range(1, 3)) begin
				b = 8'($urandom);
				if (b == START_SHORT || b == START_LONG)
					b = b ^ 8'h40;
				push_byte(b);
			end
			if (r < 2)
				push_tick();
		end else if (r < 14 || lim_payload == 16'h0000) begin
			if (lim_payload == 16'hFFFF || r < 9)
				len = 16'h0000;
			else
				len = 16'($urandom_range(int'(lim_payload) + 1, 65535));
			build_frame(FR_BAD_LEN, is_long || len > 16'd255, len);
		end else if (r < 22 && lim_timeout != 16'h0000 && lim_timeout <= 16'd20) begin
			build_frame(FR_TIMEOUT, is_long, 16'($urandom_range(1, cap)));
		end else begin
			len = 16'($urandom_range(1, cap));
			// now and then a long frame with a nonzero length high byte
			if (lim_payload >= 16'd300 && r > 94) begin
				len     = 16'($urandom_range(256, 300));
				is_long = 1'b1;
			end
			if (r < 32)
				kind = FR_BAD_CRC;
			else if (r < 40)
				kind = FR_BAD_END;
			else
				kind = FR_GOOD;
			build_frame(kind, is_long, len);
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [15:0] crc;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values: 129 is one past the reset payload limit
		push_byte(START_SHORT); push_byte(8'd129);
		wait_drained();

		// Directed: every status, field extremes, ticks inside and outside frames
		cfg_write(CFG_MAX_PAYLOAD, 16'd16);
		cfg_write(CFG_TIMEOUT_TICKS, 16'd3);
		push_byte(8'h55); push_tick();                      // ignored while hunting
		crc = crc_update(crc_update(16'h0000, 8'h00), 8'hFF);
		push_byte(START_SHORT); push_byte(8'd2); push_byte(8'h00); push_byte(8'hFF);
		push_byte(crc[15:8]); push_byte(crc[7:0]); push_byte(END_BYTE);   // ok
		push_byte(START_LONG); push_byte(8'h00); push_byte(8'h00);          // zero length
		push_byte(START_SHORT); push_byte(8'd17);                           // over limit
		crc = crc_update(16'h0000, 8'hA5);
		push_byte(START_LONG); push_byte(8'h00); push_byte(8'h01); push_byte(8'hA5);
		push_tick(); push_tick();                            // below timeout, byte clears it
		push_byte(~crc[15:8]); push_byte(crc[7:0]); push_byte(END_BYTE);  // crc mismatch
		push_byte(START_SHORT); push_byte(8'd1); push_byte(8'h5A);
		push_byte(8'h12); push_byte(8'h34); push_byte(8'h7E);              // bad end byte
		push_byte(START_LONG); push_byte(8'h12); repeat (3) push_tick();  // timeout, half length
		wait_drained();

		// Both registers zero: every length is bad, first tick in a frame times out
		cfg_write(CFG_MAX_PAYLOAD, 16'h0000);
		cfg_write(CFG_TIMEOUT_TICKS, 16'h0000);
		push_byte(START_SHORT); push_byte(8'd1);
		push_byte(START_LONG); push_tick();
		push_tick();
		wait_drained();

		// Both registers at maximum: open the largest frame, then shorten the
		// timeout while it is still open
		cfg_write(CFG_MAX_PAYLOAD, 16'hFFFF);
		cfg_write(CFG_TIMEOUT_TICKS, 16'hFFFF);
		push_byte(START_LONG); push_byte(8'hFF); push_byte(8'hFF);
		push_byte(8'h00); push_byte(8'hFF); push_byte(8'h81);
		push_tick(); push_tick();
		wait_drained();
		cfg_write(CFG_TIMEOUT_TICKS, 16'd1);
		push_tick();
		wait_drained();

		// Random phases under several register settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					cfg_write(CFG_MAX_PAYLOAD, 16'($urandom_range(8, 40)));
					cfg_write(CFG_TIMEOUT_TICKS, 16'($urandom_range(2, 20)));
				end
				1: begin
					cfg_write(CFG_MAX_PAYLOAD, 16'd100);
					cfg_write(CFG_TIMEOUT_TICKS, 16'd1);
				end
				2: begin
					cfg_write(CFG_MAX_PAYLOAD, 16'd1);
					cfg_write(CFG_TIMEOUT_TICKS, 16'($urandom_range(2, 20)));
				end
				3: begin
					cfg_write(CFG_MAX_PAYLOAD, 16'hFFFF);
					cfg_write(CFG_TIMEOUT_TICKS, 16'hFFFF);
				end
				default: begin
					cfg_write(CFG_MAX_PAYLOAD, 16'($urandom_range(1, 40)));
					cfg_write(CFG_TIMEOUT_TICKS, 16'($urandom_range(1, 20)));
				end
			endcase
			// last phase runs at full rate on both sides
			if (p == 5)
				bursts_on <= 1'b0;
			frame_items = 0;
			if (p == 1) begin
				// receiver holds off while a long frame keeps coming, so the
				// block fills and stalls its input
				build_frame(FR_GOOD, 1'b0, 16'd60);
				recv_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				recv_hold <= 1'b0;
			end
			while (frame_items < ITEMS_PER_PHASE)
				random_frame();
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/crc16pd_pkg.sv
hw/rtl/crc16pd_state_mem.sv
hw/rtl/crc16pd_frame_logic.sv
hw/rtl/crc16_packet_deframer.sv
dv/tb_crc16_packet_deframer.sv
